// ===== rtl/core/ttb_pkg.sv =====
package ttb_pkg;

  // Lane count: three tangent and three bitangent components
  localparam int unsigned LANES = 6;

  // Quotient bits produced by the divider pipe (floor of 2^21 * n / d)
  localparam int unsigned DIV_STEPS = 33;

  // Low numerator bits that are shifted into the divider one per step
  localparam int unsigned FRAC_W = 12;

  // Saturation limits for signed Q16.16
  localparam logic [31:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [31:0] SAT_NEG = 32'h8000_0000;

  // Edge or UV delta: exact difference of two signed 16-bit values
  typedef logic signed [16:0] delta_t;
  // Product of two deltas
  typedef logic signed [33:0] prod_t;
  // Difference of two products (determinant or numerator)
  typedef logic signed [34:0] wide_t;
  // Magnitude of a wide_t value
  typedef logic [33:0] mag_t;

  // Per-lane divider state
  typedef struct packed {
    mag_t                rem;   // partial remainder, below the divisor unless ovf is set
    logic [32:0]         quo;   // quotient bits so far
    logic [FRAC_W-1:0]   frac;  // numerator bits still to shift in, MSB first
    logic                ovf;   // quotient does not fit in DIV_STEPS bits
    logic                neg;   // result is negative
  } lane_t;

  // One restoring division step
  function automatic lane_t div_step(lane_t ln, mag_t d);
    logic [34:0] r2;
    logic [35:0] diff;
    lane_t       nxt;
    r2   = {ln.rem, ln.frac[FRAC_W-1]};
    diff = {1'b0, r2} - {2'b00, d};
    nxt  = ln;
    nxt.frac = {ln.frac[FRAC_W-2:0], 1'b0};
    if (!diff[35]) begin
      nxt.rem = diff[33:0];
      nxt.quo = {ln.quo[31:0], 1'b1};
    end else begin
      nxt.rem = r2[33:0];
      nxt.quo = {ln.quo[31:0], 1'b0};
    end
    return nxt;
  endfunction

endpackage

// ===== rtl/core/triangle_tangent_basis.sv =====
// Channel  Dir  Ports                                                    Transaction
// command  in   start_i, busy_o, pos_a/b/c_i, uv_a/b/c_i                 start_i && !busy_o
// result   out  done_o, tangent_*_o, bitangent_*_o, degenerate_o         done_o, one cycle
//
// One triangle may start in every cycle; busy_o stays low.
// The pipe has five setup stages (deltas, products, differences,
// magnitudes, overflow check), 33 stages of the restoring divider pipe
// (one quotient bit per stage, six lanes), then rounding and output.
// Reset clears only the valid bits; the pipe never stalls, so the receiver
// must take every result in the cycle it is shown; the block does not check it.
module triangle_tangent_basis (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [47:0]        pos_a_i,
  input  logic [47:0]        pos_b_i,
  input  logic [47:0]        pos_c_i,
  input  logic [31:0]        uv_a_i,
  input  logic [31:0]        uv_b_i,
  input  logic [31:0]        uv_c_i,
  output logic               done_o,
  output logic signed [31:0] tangent_x_o,
  output logic signed [31:0] tangent_y_o,
  output logic signed [31:0] tangent_z_o,
  output logic signed [31:0] bitangent_x_o,
  output logic signed [31:0] bitangent_y_o,
  output logic signed [31:0] bitangent_z_o,
  output logic               degenerate_o
);

  localparam int unsigned LATENCY = ttb_pkg::DIV_STEPS + 7;

  // ---------------------------------------------------------------
  // Stage 1: edges and UV deltas
  // ---------------------------------------------------------------
  logic            s1_vld_q;
  ttb_pkg::delta_t s1_e1_q [3];
  ttb_pkg::delta_t s1_e2_q [3];
  ttb_pkg::delta_t s1_d1u_q, s1_d1v_q, s1_d2u_q, s1_d2v_q;

  function automatic ttb_pkg::delta_t sub16(logic [15:0] x, logic [15:0] y);
    return ttb_pkg::delta_t'($signed(x)) - ttb_pkg::delta_t'($signed(y));
  endfunction

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      s1_e1_q[k] <= sub16(pos_b_i[16*k +: 16], pos_a_i[16*k +: 16]);
      s1_e2_q[k] <= sub16(pos_c_i[16*k +: 16], pos_a_i[16*k +: 16]);
    end
    s1_d1u_q <= sub16(uv_b_i[15:0],  uv_a_i[15:0]);
    s1_d1v_q <= sub16(uv_b_i[31:16], uv_a_i[31:16]);
    s1_d2u_q <= sub16(uv_c_i[15:0],  uv_a_i[15:0]);
    s1_d2v_q <= sub16(uv_c_i[31:16], uv_a_i[31:16]);
  end

  // ---------------------------------------------------------------
  // Stage 2: products
  // ---------------------------------------------------------------
  logic           s2_vld_q;
  ttb_pkg::prod_t s2_det_p_q, s2_det_m_q;
  ttb_pkg::prod_t s2_num_p_q [ttb_pkg::LANES];
  ttb_pkg::prod_t s2_num_m_q [ttb_pkg::LANES];

  function automatic ttb_pkg::prod_t mul17(ttb_pkg::delta_t a, ttb_pkg::delta_t b);
    return ttb_pkg::prod_t'(a) * ttb_pkg::prod_t'(b);
  endfunction

  always_ff @(posedge clk_i) begin
    s2_det_p_q <= mul17(s1_d1u_q, s1_d2v_q);
    s2_det_m_q <= mul17(s1_d2u_q, s1_d1v_q);
    for (int k = 0; k < 3; k++) begin
      // tangent = d2v * e1 - d1v * e2
      s2_num_p_q[k]   <= mul17(s1_d2v_q, s1_e1_q[k]);
      s2_num_m_q[k]   <= mul17(s1_d1v_q, s1_e2_q[k]);
      // bitangent = d1u * e2 - d2u * e1
      s2_num_p_q[3+k] <= mul17(s1_d1u_q, s1_e2_q[k]);
      s2_num_m_q[3+k] <= mul17(s1_d2u_q, s1_e1_q[k]);
    end
  end

  // ---------------------------------------------------------------
  // Stage 3: determinant and numerators
  // ---------------------------------------------------------------
  logic           s3_vld_q;
  ttb_pkg::wide_t s3_det_q;
  ttb_pkg::wide_t s3_num_q [ttb_pkg::LANES];

  always_ff @(posedge clk_i) begin
    s3_det_q <= ttb_pkg::wide_t'(s2_det_p_q) - ttb_pkg::wide_t'(s2_det_m_q);
    for (int l = 0; l < ttb_pkg::LANES; l++) begin
      s3_num_q[l] <= ttb_pkg::wide_t'(s2_num_p_q[l]) - ttb_pkg::wide_t'(s2_num_m_q[l]);
    end
  end

  // ---------------------------------------------------------------
  // Stage 4: magnitudes, result signs, zero determinant
  // ---------------------------------------------------------------
  logic          s4_vld_q;
  logic          s4_degen_q;
  ttb_pkg::mag_t s4_dmag_q;
  ttb_pkg::mag_t s4_nmag_q [ttb_pkg::LANES];
  logic          s4_neg_q  [ttb_pkg::LANES];

  function automatic ttb_pkg::mag_t abs35(ttb_pkg::wide_t x);
    ttb_pkg::wide_t a;
    a = x[34] ? -x : x;
    return a[33:0];
  endfunction

  always_ff @(posedge clk_i) begin
    s4_dmag_q  <= abs35(s3_det_q);
    s4_degen_q <= (s3_det_q == '0);
    for (int l = 0; l < ttb_pkg::LANES; l++) begin
      s4_nmag_q[l] <= abs35(s3_num_q[l]);
      s4_neg_q[l]  <= s3_num_q[l][34] ^ s3_det_q[34];
    end
  end

  // ---------------------------------------------------------------
  // Divider pipe: entry 0 is the overflow check and remainder setup,
  // entries 1..DIV_STEPS each add one quotient bit
  // ---------------------------------------------------------------
  logic [ttb_pkg::DIV_STEPS:0] div_vld_q;
  logic [ttb_pkg::DIV_STEPS:0] div_degen_q;
  ttb_pkg::mag_t               div_dmag_q [ttb_pkg::DIV_STEPS+1];
  ttb_pkg::lane_t              div_lane_q [ttb_pkg::DIV_STEPS+1][ttb_pkg::LANES];

  // Quotient needs more than DIV_STEPS bits when n >= d * 2^12
  always_ff @(posedge clk_i) begin
    div_dmag_q[0]  <= s4_dmag_q;
    div_degen_q[0] <= s4_degen_q;
    for (int l = 0; l < ttb_pkg::LANES; l++) begin
      div_lane_q[0][l].ovf  <= {12'd0, s4_nmag_q[l]} >= {s4_dmag_q, 12'd0};
      div_lane_q[0][l].rem  <= {12'd0, s4_nmag_q[l][33:ttb_pkg::FRAC_W]};
      div_lane_q[0][l].frac <= s4_nmag_q[l][ttb_pkg::FRAC_W-1:0];
      div_lane_q[0][l].quo  <= '0;
      div_lane_q[0][l].neg  <= s4_neg_q[l];
    end
    // One quotient bit per entry
    for (int s = 0; s < ttb_pkg::DIV_STEPS; s++) begin
      div_dmag_q[s+1]  <= div_dmag_q[s];
      div_degen_q[s+1] <= div_degen_q[s];
      for (int l = 0; l < ttb_pkg::LANES; l++) begin
        div_lane_q[s+1][l] <= ttb_pkg::div_step(div_lane_q[s][l], div_dmag_q[s]);
      end
    end
  end

  // ---------------------------------------------------------------
  // Round stage: q = (floor(2^21 * n / d) + 1) / 2, saturation check
  // ---------------------------------------------------------------
  logic        rnd_vld_q;
  logic        rnd_degen_q;
  logic [31:0] rnd_mag_q [ttb_pkg::LANES];
  logic        rnd_sat_q [ttb_pkg::LANES];
  logic        rnd_neg_q [ttb_pkg::LANES];

  always_ff @(posedge clk_i) begin
    logic [33:0] q;
    rnd_degen_q <= div_degen_q[ttb_pkg::DIV_STEPS];
    for (int l = 0; l < ttb_pkg::LANES; l++) begin
      q = ({1'b0, div_lane_q[ttb_pkg::DIV_STEPS][l].quo} + 34'd1) >> 1;
      rnd_mag_q[l] <= q[31:0];
      rnd_neg_q[l] <= div_lane_q[ttb_pkg::DIV_STEPS][l].neg;
      if (div_lane_q[ttb_pkg::DIV_STEPS][l].neg) begin
        rnd_sat_q[l] <= div_lane_q[ttb_pkg::DIV_STEPS][l].ovf
                        || (q > {2'b00, ttb_pkg::SAT_NEG});
      end else begin
        rnd_sat_q[l] <= div_lane_q[ttb_pkg::DIV_STEPS][l].ovf
                        || (q > {2'b00, ttb_pkg::SAT_POS});
      end
    end
  end

  // ---------------------------------------------------------------
  // Output stage: sign, saturation, zero on degenerate triangle
  // ---------------------------------------------------------------
  logic        out_vld_q;
  logic        out_degen_q;
  logic [31:0] out_res_q [ttb_pkg::LANES];

  always_ff @(posedge clk_i) begin
    out_degen_q <= rnd_degen_q;
    for (int l = 0; l < ttb_pkg::LANES; l++) begin
      if (rnd_degen_q) begin
        out_res_q[l] <= '0;
      end else if (rnd_sat_q[l]) begin
        out_res_q[l] <= rnd_neg_q[l] ? ttb_pkg::SAT_NEG : ttb_pkg::SAT_POS;
      end else begin
        out_res_q[l] <= rnd_neg_q[l] ? -rnd_mag_q[l] : rnd_mag_q[l];
      end
    end
  end

  // ---------------------------------------------------------------
  // Valid bits
  // ---------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      s4_vld_q  <= 1'b0;
      div_vld_q <= '0;
      rnd_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      s1_vld_q  <= start_i && !busy_o;
      s2_vld_q  <= s1_vld_q;
      s3_vld_q  <= s2_vld_q;
      s4_vld_q  <= s3_vld_q;
      div_vld_q <= {div_vld_q[ttb_pkg::DIV_STEPS-1:0], s4_vld_q};
      rnd_vld_q <= div_vld_q[ttb_pkg::DIV_STEPS];
      out_vld_q <= rnd_vld_q;
    end
  end

  assign done_o        = out_vld_q;
  assign degenerate_o  = out_degen_q;
  assign tangent_x_o   = out_res_q[0];
  assign tangent_y_o   = out_res_q[1];
  assign tangent_z_o   = out_res_q[2];
  assign bitangent_x_o = out_res_q[3];
  assign bitangent_y_o = out_res_q[4];
  assign bitangent_z_o = out_res_q[5];

  // ---------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------
  // Every accepted triangle gives a result after the fixed latency
  a_latency_fwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##LATENCY done_o)
    else $error("accepted triangle produced no result");

  // No result without a matching accepted triangle
  a_latency_bwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, LATENCY))
    else $error("result without matching triangle");

  // Degenerate result carries zero vectors
  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && degenerate_o |-> tangent_x_o == 0 && tangent_y_o == 0
      && tangent_z_o == 0 && bitangent_x_o == 0 && bitangent_y_o == 0
      && bitangent_z_o == 0)
    else $error("degenerate result with nonzero vector");

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps

module tb;

  // Q8.8 / Q4.12 corner values
  localparam logic [15:0] FIX_MIN = 16'h8000;
  localparam logic [15:0] FIX_MAX = 16'h7FFF;
  localparam logic [15:0] UV_ONE  = 16'h1000;
  localparam logic [15:0] POS_ONE = 16'h0100;

  // Pipe depth plus margin, and the stall limit for the watchdog
  localparam int unsigned LATENCY_CYCLES  = 45;
  localparam int unsigned WATCHDOG_CYCLES = 2000;

  typedef struct packed {
    logic [47:0] pos_a;
    logic [47:0] pos_b;
    logic [47:0] pos_c;
    logic [31:0] uv_a;
    logic [31:0] uv_b;
    logic [31:0] uv_c;
  } triangle_t;

  // Index 0 is x, 1 is y, 2 is z
  typedef struct packed {
    logic [2:0][31:0] tangent;
    logic [2:0][31:0] bitangent;
    logic             degenerate;
  } basis_t;

  logic        clk_i   = 1'b0;
  logic        rst_ni  = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic [47:0] pos_a_i = '0;
  logic [47:0] pos_b_i = '0;
  logic [47:0] pos_c_i = '0;
  logic [31:0] uv_a_i  = '0;
  logic [31:0] uv_b_i  = '0;
  logic [31:0] uv_c_i  = '0;
  logic        done_o;
  logic signed [31:0] tangent_x_o, tangent_y_o, tangent_z_o;
  logic signed [31:0] bitangent_x_o, bitangent_y_o, bitangent_z_o;
  logic        degenerate_o;

  basis_t      expected_basis_q[$];
  int unsigned mismatches   = 0;
  int unsigned stall_cycles = 0;
  int unsigned sender_idle_pct = 0;
  string       axis_name [3] = '{"x", "y", "z"};

  triangle_tangent_basis dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .pos_a_i       (pos_a_i),
    .pos_b_i       (pos_b_i),
    .pos_c_i       (pos_c_i),
    .uv_a_i        (uv_a_i),
    .uv_b_i        (uv_b_i),
    .uv_c_i        (uv_c_i),
    .done_o        (done_o),
    .tangent_x_o   (tangent_x_o),
    .tangent_y_o   (tangent_y_o),
    .tangent_z_o   (tangent_z_o),
    .bitangent_x_o (bitangent_x_o),
    .bitangent_y_o (bitangent_y_o),
    .bitangent_z_o (bitangent_z_o),
    .degenerate_o  (degenerate_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // num * 2^20 / den, round half away from zero, saturate to Q16.16
  function automatic logic [31:0] quotient_q16(longint num, longint den);
    longint unsigned n, d, q;
    logic            neg;
    neg = (num < 0) != (den < 0);
    n   = (num < 0) ? -num : num;
    n   = n << 20;
    d   = (den < 0) ? -den : den;
    q   = (2 * n + d) / (2 * d);
    if (neg) begin
      if (q > 64'h8000_0000) q = 64'h8000_0000;
      q = -q;
    end else if (q > 64'h7FFF_FFFF) begin
      q = 64'h7FFF_FFFF;
    end
    return q[31:0];
  endfunction

  // Tangent frame of one triangle from exact edges, UV deltas and determinant
  function automatic basis_t predict_basis(triangle_t tr);
    longint edge1 [3];
    longint edge2 [3];
    longint origin, d1u, d1v, d2u, d2v, det, tn, bn;
    basis_t r;
    r = '0;
    for (int k = 0; k < 3; k++) begin
      origin   = longint'($signed(tr.pos_a[16*k +: 16]));
      edge1[k] = longint'($signed(tr.pos_b[16*k +: 16])) - origin;
      edge2[k] = longint'($signed(tr.pos_c[16*k +: 16])) - origin;
    end
    d1u = longint'($signed(tr.uv_b[15:0]))  - longint'($signed(tr.uv_a[15:0]));
    d1v = longint'($signed(tr.uv_b[31:16])) - longint'($signed(tr.uv_a[31:16]));
    d2u = longint'($signed(tr.uv_c[15:0]))  - longint'($signed(tr.uv_a[15:0]));
    d2v = longint'($signed(tr.uv_c[31:16])) - longint'($signed(tr.uv_a[31:16]));
    det = d1u * d2v - d2u * d1v;
    if (det == 0) begin
      r.degenerate = 1'b1;
      return r;
    end
    for (int k = 0; k < 3; k++) begin
      tn = d2v * edge1[k] - d1v * edge2[k];
      bn = d1u * edge2[k] - d2u * edge1[k];
      r.tangent[k]   = quotient_q16(tn, det);
      r.bitangent[k] = quotient_q16(bn, det);
    end
    return r;
  endfunction

  function automatic logic [47:0] pos3(logic [15:0] x, logic [15:0] y, logic [15:0] z);
    return {z, y, x};
  endfunction

  function automatic logic [31:0] uv2(logic [15:0] u, logic [15:0] v);
    return {v, u};
  endfunction

  function automatic triangle_t make_triangle(logic [47:0] pa, logic [47:0] pb,
                                              logic [47:0] pc, logic [31:0] ua,
                                              logic [31:0] ub, logic [31:0] uc);
    triangle_t t;
    t.pos_a = pa;
    t.pos_b = pb;
    t.pos_c = pc;
    t.uv_a  = ua;
    t.uv_b  = ub;
    t.uv_c  = uc;
    return t;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      mismatches++;
    end
  endtask

  // Predict on each command transaction, check each result, watch for stalls
  always @(posedge clk_i) begin
    basis_t want, got;
    logic   accepted;
    accepted = 1'b0;
    if (rst_ni && done_o) begin
      accepted = 1'b1;
      got.tangent    = {tangent_z_o, tangent_y_o, tangent_x_o};
      got.bitangent  = {bitangent_z_o, bitangent_y_o, bitangent_x_o};
      got.degenerate = degenerate_o;
      if (expected_basis_q.size() == 0) begin
        $error("result with no triangle outstanding");
        mismatches++;
      end else begin
        want = expected_basis_q.pop_front();
        for (int k = 0; k < 3; k++) begin
          check_field({"tangent_", axis_name[k]}, want.tangent[k], got.tangent[k]);
          check_field({"bitangent_", axis_name[k]}, want.bitangent[k], got.bitangent[k]);
        end
        check_field("degenerate", 32'(want.degenerate), 32'(got.degenerate));
      end
    end
    if (rst_ni && start_i && !busy_o) begin
      accepted = 1'b1;
      expected_basis_q.insert(expected_basis_q.size(),
                              predict_basis(make_triangle(pos_a_i, pos_b_i, pos_c_i,
                                                          uv_a_i, uv_b_i, uv_c_i)));
    end
    stall_cycles = accepted ? 0 : stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_CYCLES) begin
      $display("triangle_tangent_basis regression: fail");
      $finish;
    end
  end

  // Present one triangle until taken, then idle cycle by cycle at the set rate
  task automatic send_triangle(triangle_t t);
    start_i <= 1'b1;
    pos_a_i <= t.pos_a;
    pos_b_i <= t.pos_b;
    pos_c_i <= t.pos_c;
    uv_a_i  <= t.uv_a;
    uv_b_i  <= t.uv_b;
    uv_c_i  <= t.uv_c;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    while ($urandom_range(99) < sender_idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  // Hold off new triangles until every outstanding result is back
  task automatic drain_results();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (expected_basis_q.size() != 0) @(posedge clk_i);
  endtask

  // UV unit square: tangent equals edge1, bitangent equals edge2
  task automatic test_unit_square();
    logic [31:0] ua, ub, uc;
    ua = uv2(16'h0000, 16'h0000);
    ub = uv2(UV_ONE, 16'h0000);
    uc = uv2(16'h0000, UV_ONE);
    send_triangle(make_triangle(pos3(0, 0, 0), pos3(POS_ONE, 0, 0), pos3(0, POS_ONE, 0),
                                ua, ub, uc));
    send_triangle(make_triangle(pos3(16'hFF00, 16'h0080, 16'h1234),
                                pos3(16'h0300, 16'hFE80, 16'hEDCC),
                                pos3(16'h0001, 16'hFFFF, 16'h0000), ua, ub, uc));
    send_triangle(make_triangle(pos3(FIX_MIN, FIX_MAX, FIX_MIN), pos3(FIX_MAX, FIX_MIN, FIX_MAX),
                                pos3(FIX_MAX, FIX_MAX, FIX_MIN), ua, ub, uc));
  endtask

  // Zero determinant: equal UVs, a zero delta, collinear deltas
  task automatic test_degenerate();
    send_triangle(make_triangle(pos3(FIX_MIN, FIX_MIN, FIX_MIN), pos3(FIX_MAX, FIX_MAX, FIX_MAX),
                                pos3(FIX_MAX, FIX_MIN, FIX_MAX), 32'h1234_5678, 32'h1234_5678,
                                32'h1234_5678));
    send_triangle(make_triangle(pos3(0, POS_ONE, 0), pos3(POS_ONE, 0, 0), pos3(0, 0, POS_ONE),
                                uv2(UV_ONE, 0), uv2(UV_ONE, 0), uv2(0, UV_ONE)));
    send_triangle(make_triangle(pos3(0, 0, 0), pos3(POS_ONE, 0, 0), pos3(0, POS_ONE, 0),
                                uv2(0, 0), uv2(UV_ONE, UV_ONE), uv2(16'h2000, 16'h2000)));
    send_triangle(make_triangle(pos3(FIX_MAX, FIX_MAX, FIX_MAX), pos3(FIX_MIN, FIX_MIN, FIX_MIN),
                                pos3(0, 0, 0), uv2(FIX_MIN, FIX_MIN), uv2(FIX_MAX, FIX_MAX),
                                uv2(FIX_MIN, FIX_MIN)));
  endtask

  // Full-range UV spans and positions, both signs of the determinant
  task automatic test_extremes();
    send_triangle(make_triangle(pos3(FIX_MIN, FIX_MIN, FIX_MIN), pos3(FIX_MAX, FIX_MAX, FIX_MAX),
                                pos3(FIX_MAX, FIX_MAX, FIX_MAX), uv2(FIX_MIN, FIX_MIN),
                                uv2(FIX_MAX, FIX_MIN), uv2(FIX_MIN, FIX_MAX)));
    send_triangle(make_triangle(pos3(FIX_MIN, FIX_MIN, FIX_MIN), pos3(FIX_MAX, FIX_MIN, FIX_MAX),
                                pos3(FIX_MIN, FIX_MAX, FIX_MAX), uv2(FIX_MIN, FIX_MIN),
                                uv2(FIX_MIN, FIX_MAX), uv2(FIX_MAX, FIX_MIN)));
    send_triangle(make_triangle(pos3(FIX_MAX, FIX_MAX, FIX_MAX), pos3(FIX_MIN, FIX_MIN, FIX_MIN),
                                pos3(FIX_MIN, FIX_MAX, FIX_MIN), uv2(FIX_MAX, FIX_MAX),
                                uv2(FIX_MIN, FIX_MAX), uv2(FIX_MAX, FIX_MIN)));
    send_triangle(make_triangle(48'hFFFF_FFFF_FFFF, 48'h0000_0000_0000, 48'hFFFF_0000_FFFF,
                                32'hFFFF_FFFF, 32'h0000_0000, 32'h7FFF_8000));
  endtask

  // Determinant of magnitude one with large numerators overflows Q16.16; the last has a large determinant
  task automatic test_saturation();
    send_triangle(make_triangle(pos3(FIX_MIN, FIX_MAX, FIX_MIN), pos3(FIX_MAX, FIX_MIN, FIX_MAX),
                                pos3(FIX_MIN, FIX_MIN, FIX_MAX), uv2(0, 0), uv2(1, 0), uv2(0, 1)));
    send_triangle(make_triangle(pos3(FIX_MIN, FIX_MAX, FIX_MIN), pos3(FIX_MAX, FIX_MIN, FIX_MAX),
                                pos3(FIX_MIN, FIX_MIN, FIX_MAX), uv2(0, 0), uv2(0, 1), uv2(1, 0)));
    send_triangle(make_triangle(pos3(0, 0, 0), pos3(16'h0800, 16'hF800, 16'h07FF),
                                pos3(16'hF801, 16'h0800, 16'h0000), uv2(0, 0), uv2(1, 0),
                                uv2(0, 1)));
    send_triangle(make_triangle(pos3(0, 0, 0), pos3(1, 16'hFFFF, 2), pos3(2, 1, 16'hFFFE),
                                uv2(FIX_MAX, FIX_MAX), uv2(16'h8002, FIX_MAX),
                                uv2(FIX_MAX, 16'h7FFC)));
  endtask

  // Exact half-way quotients of both signs, and determinants of plus and minus three
  task automatic test_rounding();
    send_triangle(make_triangle(pos3(0, 0, 0), pos3(0, 0, 0), pos3(16'hFFFD, 0, 3),
                                uv2(0, 0), uv2(16'h0800, 1), uv2(0, 16'h0400)));
    send_triangle(make_triangle(pos3(0, 0, 0), pos3(1, 2, 16'hFFFF), pos3(16'hFFFE, 1, 3),
                                uv2(0, 0), uv2(3, 0), uv2(0, 1)));
    send_triangle(make_triangle(pos3(5, 5, 5), pos3(6, 3, 16'hFFF0), pos3(5, 6, 7),
                                uv2(16'hFFFF, 0), uv2(2, 0), uv2(16'hFFFF, 16'hFFFF)));
  endtask

  // Mix of degenerate, collinear, tiny-determinant, textured-mesh and raw triangles
  function automatic triangle_t random_triangle();
    triangle_t   t;
    logic [15:0] du, dv;
    int unsigned mode;
    mode    = $urandom_range(9);
    t.pos_a = {16'($urandom), 32'($urandom)};
    t.pos_b = {16'($urandom), 32'($urandom)};
    t.pos_c = {16'($urandom), 32'($urandom)};
    t.uv_a  = $urandom;
    t.uv_b  = $urandom;
    t.uv_c  = $urandom;
    case (mode)
      0: begin
        t.uv_b = t.uv_a;
      end
      1: begin
        t.uv_a = uv2(16'($urandom_range(0, 4096)), 16'($urandom_range(0, 4096)));
        du = 16'($urandom_range(0, 1022) - 511);
        dv = 16'($urandom_range(0, 1022) - 511);
        t.uv_b = uv2(t.uv_a[15:0] + du, t.uv_a[31:16] + dv);
        t.uv_c = uv2(t.uv_a[15:0] + 16'(2 * du), t.uv_a[31:16] + 16'(2 * dv));
      end
      2: begin
        t.uv_b = uv2(t.uv_a[15:0] + 16'($urandom_range(0, 4) - 2),
                     t.uv_a[31:16] + 16'($urandom_range(0, 4) - 2));
        t.uv_c = uv2(t.uv_a[15:0] + 16'($urandom_range(0, 4) - 2),
                     t.uv_a[31:16] + 16'($urandom_range(0, 4) - 2));
      end
      3, 4, 5, 6: begin
        t.uv_a = uv2(16'($urandom_range(0, 4096)), 16'($urandom_range(0, 4096)));
        t.uv_b = uv2(16'($urandom_range(0, 4096)), 16'($urandom_range(0, 4096)));
        t.uv_c = uv2(16'($urandom_range(0, 4096)), 16'($urandom_range(0, 4096)));
      end
      default: ;
    endcase
    return t;
  endfunction

  task automatic test_random(int unsigned count, int unsigned idle_pct);
    sender_idle_pct = idle_pct;
    repeat (count) send_triangle(random_triangle());
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    sender_idle_pct = 30;
    test_unit_square();
    test_degenerate();
    test_extremes();
    test_saturation();
    test_rounding();
    drain_results();

    test_random(570, 19);
    drain_results();
    test_random(570, 78);
    drain_results();
    test_random(570, 0);
    drain_results();

    repeat (LATENCY_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && expected_basis_q.size() == 0) begin
      $display("triangle_tangent_basis regression: pass");
    end else begin
      $display("triangle_tangent_basis regression: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/ttb_pkg.sv
rtl/core/triangle_tangent_basis.sv
verif/tb.sv
